// File: hdl/lsac_pkg.sv
// ---------------------------------------------------------------------------
// lsac_pkg: shared types and constants for the LRU set-associative cache
// Geometry, row layout, access codes, lookup status and counter helper.
// ---------------------------------------------------------------------------
package lsac_pkg;

  // cache geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int COUNT_W      = 32;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NWAY_W       = $clog2(MAX_WAYS + 1);
  localparam int AGE_W        = WAY_W;
  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 64;
  localparam int TOT_W        = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // stream payload widths
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_e;

  // one set: all ways side by side
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  // lookup outcome handed from the lookup logic to the counters
  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
    logic wr;
  } lkp_res_t;

  // saturating counter add
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] cnt,
                                                 input logic [1:0]         inc);
    logic [COUNT_W:0] sum;
    sum = {1'b0, cnt} + (COUNT_W+1)'(inc);
    return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  endfunction

endpackage

// File: hdl/lsac_addr_dec.sv
// ---------------------------------------------------------------------------
// lsac_addr_dec: address split into set index and tag
// Applies the configured block and set bit counts to a byte address.
// ---------------------------------------------------------------------------
module lsac_addr_dec
  import lsac_pkg::*;
(
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [2:0]        set_bits_i,
  input  logic [5:0]        block_bits_i,
  output logic [SET_W-1:0]  set_o,
  output logic [TAG_W-1:0]  tag_o
);

  logic [2:0]        s_cl;
  logic [6:0]        tag_sh;
  logic [ADDR_W-1:0] off_addr;
  logic [SET_W:0]    set_mask;

  // clamp set bits to the implemented maximum
  assign s_cl = (set_bits_i > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_i;

  // set index: bits just above the block offset
  assign off_addr = addr_i >> block_bits_i;
  assign set_mask = ((SET_W+1)'(1) << s_cl) - (SET_W+1)'(1);
  assign set_o    = off_addr[SET_W-1:0] & set_mask[SET_W-1:0];

  // tag: everything above offset and set, zero once the shift runs off the word
  assign tag_sh = 7'(block_bits_i) + 7'(s_cl);
  assign tag_o  = tag_sh[6] ? '0 : (addr_i >> tag_sh[5:0]);

endmodule

// File: hdl/lsac_tag_store.sv
// ---------------------------------------------------------------------------
// lsac_tag_store: set row memory with per-set valid flags and forwarding
// One row read per accepted request, one row write per finished load, store or modify.
// ---------------------------------------------------------------------------
module lsac_tag_store
  import lsac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_addr_i,
  input  row_t             wr_row_i,
  input  logic [SET_W-1:0] lkp_set_i,
  output row_t             row_o
);

  row_t                row_mem_q [NUM_SETS];
  row_t                rdata_q;
  logic                rvld_q;
  logic [NUM_SETS-1:0] row_vld_q;
  row_t                fwd_row_q;
  logic [SET_W-1:0]    fwd_set_q;
  logic                fwd_vld_q;
  row_t                clr_row;

  // row memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= row_mem_q[rd_addr_i];
    end
  end

  // per-set written flags, captured alongside the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  // last written row, newest contents of its set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_row_q <= wr_row_i;
      fwd_set_q <= wr_addr_i;
    end
  end

  // never written set reads as empty
  always_comb begin
    clr_row       = rdata_q;
    clr_row.valid = '0;
    clr_row.age   = '0;
  end

  assign row_o = (fwd_vld_q && fwd_set_q == lkp_set_i) ? fwd_row_q :
                 (rvld_q ? rdata_q : clr_row);

  // a written set is marked as written from the next cycle on
  a_wr_marks_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> row_vld_q[$past(wr_addr_i)])
    else $error("written set not marked valid");

  // forwarding source tracks the last write
  a_fwd_follows_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> fwd_vld_q && fwd_set_q == $past(wr_addr_i))
    else $error("forwarding register missed a write");

endmodule

// File: hdl/lsac_lru_upd.sv
// ---------------------------------------------------------------------------
// lsac_lru_upd: way compare, victim choice and LRU age update
// Works on one set row; produces the updated row and the access outcome.
// ---------------------------------------------------------------------------
module lsac_lru_upd
  import lsac_pkg::*;
(
  input  row_t             row_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [3:0]       ways_i,
  output row_t             row_o,
  output lkp_res_t         res_o
);

  logic [NWAY_W-1:0]   nw;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] inval;
  logic                op_ok;
  logic                hit;
  logic                any_inv;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    inv_idx;
  logic [WAY_W-1:0]    old_idx;
  logic [WAY_W-1:0]    sel;
  logic [AGE_W:0]      ref_age;

  // clamp the number of ways in use
  assign nw = (ways_i == 4'd0) ? NWAY_W'(1) :
              ((ways_i > 4'(MAX_WAYS)) ? NWAY_W'(MAX_WAYS) : NWAY_W'(ways_i));

  assign op_ok = (op_i == OP_LOAD) || (op_i == OP_STORE) || (op_i == OP_MODIFY);

  // per-way compare
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = NWAY_W'(w) < nw;
      match[w]  = in_use[w] && row_i.valid[w] && (row_i.tag[w] == tag_i);
      inval[w]  = in_use[w] && !row_i.valid[w];
    end
  end

  // lowest matching way, lowest invalid way, oldest way (ties to lowest)
  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    old_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_idx = WAY_W'(w);
      end
      if (inval[w]) begin
        inv_idx = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && row_i.age[w] > row_i.age[old_idx]) begin
        old_idx = WAY_W'(w);
      end
    end
  end

  assign hit     = |match;
  assign any_inv = |inval;
  assign sel     = hit ? hit_idx : (any_inv ? inv_idx : old_idx);
  // ages below the reference grow up to the top age; filling an empty way ages all in-use valid lines
  assign ref_age = (!hit && any_inv) ? (AGE_W+1)'(MAX_WAYS) : {1'b0, row_i.age[sel]};

  // updated row
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && WAY_W'(w) != sel && row_i.valid[w] &&
          {1'b0, row_i.age[w]} < ref_age && row_i.age[w] != AGE_W'(MAX_WAYS - 1)) begin
        row_o.age[w] = row_i.age[w] + AGE_W'(1);
      end
    end
    row_o.age[sel]   = '0;
    row_o.valid[sel] = 1'b1;
    if (!hit) begin
      row_o.tag[sel] = tag_i;
    end
  end

  // outcome
  always_comb begin
    res_o.hit   = op_ok && hit;
    res_o.miss  = op_ok && !hit;
    res_o.evict = op_ok && !hit && !any_inv;
    res_o.wr    = op_ok;
  end

endmodule

// File: hdl/lsac_stats.sv
// ---------------------------------------------------------------------------
// lsac_stats: saturating totals and result register
// Updates the running counts and holds one result for the master side.
// ---------------------------------------------------------------------------
module lsac_stats
  import lsac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  lkp_res_t              res_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  logic [COUNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [COUNT_W-1:0] miss_cnt_q, miss_cnt_d;
  logic [COUNT_W-1:0] evict_cnt_q, evict_cnt_d;
  logic               out_vld_q;
  logic [2:0]         flags_q;
  logic [1:0]         hit_inc;
  logic               is_mod;

  // a modify adds its second access as a hit
  assign is_mod  = (op_i == OP_MODIFY);
  assign hit_inc = res_i.hit ? (is_mod ? 2'd2 : 2'd1) :
                   ((res_i.miss && is_mod) ? 2'd1 : 2'd0);

  assign hit_cnt_d   = sat_add(hit_cnt_q, hit_inc);
  assign miss_cnt_d  = sat_add(miss_cnt_q, {1'b0, res_i.miss});
  assign evict_cnt_d = sat_add(evict_cnt_q, {1'b0, res_i.evict});

  // counters and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (load_i) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
        out_vld_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q   <= 1'b0;
      end
    end
  end

  // result flags
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= {res_i.evict, res_i.miss, res_i.hit};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {5'd0, evict_cnt_q[TOT_W-1:0], miss_cnt_q[TOT_W-1:0],
                        hit_cnt_q[TOT_W-1:0], flags_q};

  // totals never go down
  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> hit_cnt_q >= $past(hit_cnt_q) && miss_cnt_q >= $past(miss_cnt_q) &&
               evict_cnt_q >= $past(evict_cnt_q))
    else $error("total decreased");

endmodule

// File: hdl/lru_set_assoc_cache_sim.sv
// ---------------------------------------------------------------------------
// lru_set_assoc_cache_sim: set-associative cache with true LRU replacement
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser op, tdata address
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata flags and totals
//   cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One request per cycle unless a stalled result holds it back. Acceptance reads
// the set row from memory; the lookup stage then compares the ways, updates LRU
// ages, writes the row back (forwarded to the next request) and loads the result.
// After reset all sets read empty and the totals are zero; no clearing pass.
// A stalled result holds the lookup stage, which then holds the input side.
// ---------------------------------------------------------------------------
module lru_set_assoc_cache_sim
  import lsac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] address
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] was_hit, [1] was_miss,
                                                // [2] was_eviction, [34:3] hit_total,
                                                // [66:35] miss_total,
                                                // [98:67] eviction_total, rest zero
);

  logic [2:0]       set_bits_q;
  logic [3:0]       ways_q;
  logic [5:0]       block_bits_q;

  logic             s1_vld_q, s1_vld_d;
  logic [OP_W-1:0]  s1_op_q;
  logic [SET_W-1:0] s1_set_q;
  logic [TAG_W-1:0] s1_tag_q;

  logic             in_acc;
  logic             s1_adv;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  row_t             cur_row;
  row_t             new_row;
  lkp_res_t         lkp_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd0;
      ways_q       <= 4'd1;
      block_bits_q <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[5:0];
        default:        ;
      endcase
    end
  end

  // handshake: lookup stage moves when the result register is free
  assign s1_adv        = s1_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  lsac_addr_dec u_addr_dec (
    .addr_i       (s_axis_tdata),
    .set_bits_i   (set_bits_q),
    .block_bits_i (block_bits_q),
    .set_o        (in_set),
    .tag_o        (in_tag)
  );

  // lookup stage registers
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= s_axis_tuser;
      s1_set_q <= in_set;
      s1_tag_q <= in_tag;
    end
  end

  lsac_tag_store u_tag_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_set),
    .wr_en_i   (s1_adv && lkp_res.wr),
    .wr_addr_i (s1_set_q),
    .wr_row_i  (new_row),
    .lkp_set_i (s1_set_q),
    .row_o     (cur_row)
  );

  lsac_lru_upd u_lru_upd (
    .row_i  (cur_row),
    .tag_i  (s1_tag_q),
    .op_i   (s1_op_q),
    .ways_i (ways_q),
    .row_o  (new_row),
    .res_o  (lkp_res)
  );

  lsac_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .res_i       (lkp_res),
    .op_i        (s1_op_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // a valid access either hits or misses, never both
  a_hit_xor_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && lkp_res.wr |-> lkp_res.hit ^ lkp_res.miss)
    else $error("access both hit and missed");

  // eviction only on a miss
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && lkp_res.evict |-> lkp_res.miss)
    else $error("eviction without miss");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the LRU set-associative cache
// Streams load, store, modify and unused-code requests into the cache, keeps
// a behavioral copy of the tags, valid bits, LRU ages and saturating totals,
// and checks every result field against it under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  import lsac_pkg::*;

  localparam int               CLK_HALF     = 10;
  localparam int               PIPE_LATENCY = 2;
  localparam int               STALL_LIMIT  = 2000;
  localparam int               NUM_LINES    = NUM_SETS * MAX_WAYS;
  localparam int               PAD_LSB      = 3 + 3 * TOT_W;
  localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
  localparam logic [AGE_W-1:0] AGE_MAX      = AGE_W'(MAX_WAYS - 1);

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_eviction;
    logic [TOT_W-1:0] hit_total;
    logic [TOT_W-1:0] miss_total;
    logic [TOT_W-1:0] eviction_total;
  } access_outcome_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [63:0] address
  logic [OP_W-1:0]       s_axis_tuser  = '0;   // [1:0] op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] was_hit, [1] was_miss,
                                               // [2] was_eviction, [34:3] hit_total,
                                               // [66:35] miss_total,
                                               // [98:67] eviction_total, rest zero

  // shadow copy of the cache
  logic [2:0]       shadow_set_bits   = 3'd0;
  logic [3:0]       shadow_ways       = 4'd1;
  logic [5:0]       shadow_block_bits = 6'd0;
  logic             cache_valid [NUM_LINES] = '{default: 1'b0};
  logic [TAG_W-1:0] cache_tag   [NUM_LINES] = '{default: '0};
  logic [AGE_W-1:0] cache_age   [NUM_LINES] = '{default: '0};
  logic [TOT_W-1:0] hit_cnt   = '0;
  logic [TOT_W-1:0] miss_cnt  = '0;
  logic [TOT_W-1:0] evict_cnt = '0;

  access_outcome_t pending_outcomes[$];
  int              fail_count        = 0;
  int              stall_cycles      = 0;
  int              sink_hold_cycles  = 0;
  bit              source_idle_en    = 1'b1;
  bit              sink_idle_en      = 1'b1;

  // effective geometry as the stimulus sees it
  int geo_set_bits   = 0;
  int geo_ways       = 1;
  int geo_block_bits = 0;

  lru_set_assoc_cache_sim dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // saturating total update
  function automatic logic [TOT_W-1:0] bump_total(logic [TOT_W-1:0] cnt, int n);
    if (cnt > {TOT_W{1'b1}} - TOT_W'(n)) return '1;
    return cnt + TOT_W'(n);
  endfunction

  // make one way the youngest; other valid lines below the limit age by one, up to the top age
  function automatic void refresh_ages(int base, int nw, int way, int limit);
    for (int w = 0; w < nw; w++) begin
      if (w != way && cache_valid[base+w] && int'(cache_age[base+w]) < limit &&
          cache_age[base+w] < AGE_MAX) begin
        cache_age[base+w] = cache_age[base+w] + AGE_W'(1);
      end
    end
    cache_age[base+way] = '0;
  endfunction

  // lookup, fill or evict, and the totals after this request
  function automatic access_outcome_t lru_access(logic [OP_W-1:0] op,
                                                 logic [ADDR_W-1:0] addr);
    access_outcome_t  res;
    int               set_w, nw, off_w, set_idx, base, found, victim;
    logic [TAG_W-1:0] tag;
    res = '0;
    if (op != OP_UNUSED) begin
      set_w   = (shadow_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(shadow_set_bits);
      nw      = (shadow_ways == 0) ? 1 :
                ((shadow_ways > MAX_WAYS) ? MAX_WAYS : int'(shadow_ways));
      off_w   = int'(shadow_block_bits);
      set_idx = int'((addr >> off_w) & ((64'd1 << set_w) - 64'd1));
      tag     = (off_w + set_w >= ADDR_W) ? '0 : (addr >> (off_w + set_w));
      base    = set_idx * MAX_WAYS;
      found   = nw;
      for (int w = 0; w < nw; w++) begin
        if (found == nw && cache_valid[base+w] && cache_tag[base+w] == tag) found = w;
      end
      if (found < nw) begin
        res.was_hit = 1'b1;
        refresh_ages(base, nw, found, int'(cache_age[base+found]));
        hit_cnt = bump_total(hit_cnt, (op == OP_MODIFY) ? 2 : 1);
      end else begin
        res.was_miss = 1'b1;
        victim = nw;
        for (int w = 0; w < nw; w++) begin
          if (victim == nw && !cache_valid[base+w]) victim = w;
        end
        if (victim < nw) begin
          refresh_ages(base, nw, victim, 256);
        end else begin
          // oldest way goes, lowest index on a tie
          victim = 0;
          for (int w = 1; w < nw; w++) begin
            if (cache_age[base+w] > cache_age[base+victim]) victim = w;
          end
          res.was_eviction = 1'b1;
          refresh_ages(base, nw, victim, int'(cache_age[base+victim]));
        end
        cache_valid[base+victim] = 1'b1;
        cache_tag[base+victim]   = tag;
        miss_cnt = bump_total(miss_cnt, 1);
        if (res.was_eviction) evict_cnt = bump_total(evict_cnt, 1);
        if (op == OP_MODIFY) hit_cnt = bump_total(hit_cnt, 1);
      end
    end
    res.hit_total      = hit_cnt;
    res.miss_total     = miss_cnt;
    res.eviction_total = evict_cnt;
    return res;
  endfunction

  function automatic void check_field(string name, logic [TOT_W-1:0] want,
                                      logic [TOT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checking first, then register writes and new requests
  always @(posedge clk_i) begin : scoreboard
    access_outcome_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("was_hit", TOT_W'(want.was_hit), TOT_W'(m_axis_tdata[0]));
          check_field("was_miss", TOT_W'(want.was_miss), TOT_W'(m_axis_tdata[1]));
          check_field("was_eviction", TOT_W'(want.was_eviction),
                      TOT_W'(m_axis_tdata[2]));
          check_field("hit_total", want.hit_total, m_axis_tdata[34:3]);
          check_field("miss_total", want.miss_total, m_axis_tdata[66:35]);
          check_field("eviction_total", want.eviction_total, m_axis_tdata[98:67]);
          check_field("padding", '0, TOT_W'(m_axis_tdata[OUT_DATA_W-1:PAD_LSB]));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS:   shadow_set_bits   = cfg_data_i[2:0];
          CFG_WAYS:       shadow_ways       = cfg_data_i[3:0];
          CFG_BLOCK_BITS: shadow_block_bits = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_outcomes.push_back(lru_access(s_axis_tuser, s_axis_tdata));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls per result, plus a long hold on request
  initial begin : result_sink
    int wait_cycles;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else if (sink_idle_en) begin
        wait_cycles = $urandom_range(0, 4);
        if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // one request, after a random gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = source_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  // reprogram all three registers while the cache is idle
  task automatic set_geometry(input int sb, input int nw, input int bb);
    drain_results();
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_WAYS, nw);
    write_reg(CFG_BLOCK_BITS, bb);
    cfg_we_i <= 1'b0;
    geo_set_bits   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    geo_ways       = (nw == 0) ? 1 : ((nw > MAX_WAYS) ? MAX_WAYS : nw);
    geo_block_bits = bb;
  endtask

  function automatic logic [ADDR_W-1:0] compose_addr(logic [TAG_W-1:0] tag, int set_idx,
                                                     logic [ADDR_W-1:0] offset);
    logic [ADDR_W-1:0] off_mask, set_mask;
    off_mask = ~({ADDR_W{1'b1}} << geo_block_bits);
    set_mask = (64'd1 << geo_set_bits) - 64'd1;
    return (tag << (geo_block_bits + geo_set_bits)) |
           ((ADDR_W'(set_idx) & set_mask) << geo_block_bits) | (offset & off_mask);
  endfunction

  // defaults after reset: one set, one way, no offset
  task automatic test_reset_state();
    send_request(OP_LOAD, 64'd0);
    send_request(OP_LOAD, 64'd0);
    send_request(OP_STORE, 64'd1);
    send_request(OP_MODIFY, 64'd1);
    send_request(OP_MODIFY, 64'd2);
    send_request(OP_UNUSED, {ADDR_W{1'b1}});
  endtask

  // two ways: fill, refresh, evict the least recently used, field extremes
  task automatic test_lru_order();
    set_geometry(2, 2, 4);
    send_request(OP_LOAD, compose_addr(64'h1, 1, 64'h0));
    send_request(OP_STORE, compose_addr(64'h2, 1, 64'hF));
    send_request(OP_LOAD, compose_addr(64'h1, 1, 64'h7));
    send_request(OP_MODIFY, compose_addr(64'h3, 1, 64'h0));
    send_request(OP_LOAD, compose_addr(64'h2, 1, 64'h0));
    send_request(OP_STORE, {ADDR_W{1'b1}});
    send_request(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_MODIFY, 64'h5555_5555_5555_5555);
    send_request(OP_UNUSED, 64'd0);
  endtask

  // clamped register values and shifts that push the tag off the address
  task automatic test_geometry_extremes();
    set_geometry(7, 0, 63);
    send_request(OP_LOAD, {ADDR_W{1'b1}});
    send_request(OP_LOAD, 64'd0);
    send_request(OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
    set_geometry(6, 15, 58);
    send_request(OP_LOAD, 64'hFC00_0000_0000_0000);
    send_request(OP_MODIFY, 64'hFC00_0000_0000_1234);
    set_geometry(0, 8, 32);
    send_request(OP_STORE, 64'hDEAD_BEEF_0000_0001);
  endtask

  // lines beyond a reduced way count keep their tags
  task automatic test_ways_shrink();
    set_geometry(1, 4, 0);
    for (int t = 10; t < 14; t++) send_request(OP_STORE, compose_addr(TAG_W'(t), 0, '0));
    set_geometry(1, 1, 0);
    send_request(OP_LOAD, compose_addr(64'd12, 0, '0));
    set_geometry(1, 4, 0);
    send_request(OP_LOAD, compose_addr(64'd12, 0, '0));
    send_request(OP_LOAD, compose_addr(64'd10, 0, '0));
  endtask

  // result side holds off while requests keep coming, then a full pause
  task automatic test_backpressure();
    set_geometry(3, 4, 2);
    source_idle_en   = 1'b0;
    sink_hold_cycles = 60;
    for (int i = 0; i < 30; i++) begin
      send_request(OP_W'($urandom_range(0, 2)),
                   compose_addr(TAG_W'($urandom_range(0, 5)), $urandom_range(0, 3), '0));
    end
    source_idle_en = 1'b1;
    drain_results();
  endtask

  // random geometry per phase, mostly reuse of a small tag pool
  task automatic test_random_traffic();
    logic [TAG_W-1:0]  tag_pool [12];
    logic [ADDR_W-1:0] addr;
    logic [OP_W-1:0]   op;
    int                bb;
    for (int phase = 0; phase < 12; phase++) begin
      bb = (phase % 4 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
      set_geometry($urandom_range(0, 7), $urandom_range(0, 15), bb);
      source_idle_en = (phase % 3 != 1);
      sink_idle_en   = (phase % 3 != 2);
      foreach (tag_pool[k]) tag_pool[k] = {$urandom, $urandom};
      for (int i = 0; i < 80; i++) begin
        op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 85) begin
          addr = compose_addr(tag_pool[$urandom_range(0, geo_ways + 1)],
                              $urandom_range(0, 3), {$urandom, $urandom});
        end else begin
          addr = {$urandom, $urandom};
        end
        send_request(op, addr);
      end
    end
    source_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_lru_order();
    test_geometry_extremes();
    test_ways_shrink();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
